>>> sv/mrpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mrpt_pkg;
    localparam int VW = 32;
    localparam int CW = $clog2(VW);

    typedef struct packed {
        logic          start;
        logic [VW-1:0] a;
        logic [VW-1:0] b;
    } mul_req_t;

    function automatic logic [VW-1:0] base_of(input logic [1:0] idx);
        logic [VW-1:0] r;
        case (idx)
            2'd0:    r = VW'(2);
            2'd1:    r = VW'(7);
            default: r = VW'(61);
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

>>> sv/mrpt_modmul.sv
`timescale 1ns / 1ps
`default_nettype none
module mrpt_modmul import mrpt_pkg::*; (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mul_req_t      req,
    input  wire logic [VW-1:0] modulus,
    output logic               done,
    output logic [VW-1:0]      result
);
    logic [VW-1:0] a_reg, a_next, b_reg, b_next, acc_reg, acc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [VW:0]   dbl, dbl_r, sum, sum_r;

    always_comb
    begin
        dbl   = {acc_reg, 1'b0};
        dbl_r = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
        sum   = dbl_r + (a_reg[VW-1] ? {1'b0, b_reg} : '0);
        sum_r = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
        a_next = a_reg; b_next = b_reg; acc_next = acc_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        if (req.start)
        begin
            a_next = req.a; b_next = req.b; acc_next = '0;
            cnt_next = '0; busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one multiplier bit per cycle, msb first
            acc_next = sum_r[VW-1:0];
            a_next   = {a_reg[VW-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(VW-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;
endmodule
`default_nettype wire

>>> sv/miller_rabin_prime_test_core.sv
// Miller-Rabin primality test, bases 2, 7 and 61, for 32-bit candidates.
// Input channel: in_valid / in_ready with the candidate word. A word is
// taken only while the core is idle; in_ready is low while a test runs.
// Output channel: out_valid / out_ready with prime_flag, one result word
// for each candidate, held in an output register until taken.
// Every modular product goes through one shared shift-add modular
// multiplier that retires one bit a cycle.
// Trailing zeros of n-1 are stripped once per word.
// Each base then runs 32 square steps, a multiply by the base for each set
// bit of d, then up to s-1 further squarings.
// Candidates 0 and 1 are reported not prime without a test, and most
// composites finish after the first base.
// Reset clears the sequencer and the output valid flag; no word is pending.
// If the receiver stalls, the finished result waits in the output register
// and a new candidate is still taken; its result waits for the slot.
`timescale 1ns / 1ps
`default_nettype none
module miller_rabin_prime_test_core import mrpt_pkg::*; (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [31:0]   candidate,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic               prime_flag
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_STRIP = 4'd1;
    localparam logic [3:0] S_BASE  = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_SQW   = 4'd4;
    localparam logic [3:0] S_ML    = 4'd5;
    localparam logic [3:0] S_MLW   = 4'd6;
    localparam logic [3:0] S_NB    = 4'd7;
    localparam logic [3:0] S_CHK   = 4'd8;
    localparam logic [3:0] S_LOOP  = 4'd9;
    localparam logic [3:0] S_LW    = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [VW-1:0] n_reg, n_next, d_reg, d_next, x_reg, x_next;
    logic [CW-1:0] s_reg, s_next, r_reg, r_next, bit_reg, bit_next;
    logic [1:0]    idx_reg, idx_next;
    logic          res_reg, res_next;
    logic          ov_reg, ov_next, pf_reg, pf_next;
    mul_req_t      req;
    logic          mul_done;
    logic [VW-1:0] mul_res, base, nm1;

    mrpt_modmul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .modulus (n_reg),
        .done    (mul_done),
        .result  (mul_res)
    );

    assign base     = base_of(idx_reg);
    assign nm1      = n_reg - 1'b1;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg; n_next = n_reg; d_next = d_reg; x_next = x_reg;
        s_next = s_reg; r_next = r_reg; bit_next = bit_reg; idx_next = idx_reg;
        res_next = res_reg; ov_next = ov_reg; pf_next = pf_reg;
        req = '{start: 1'b0, a: x_reg, b: x_reg};
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    n_next   = candidate[VW-1:0];
                    d_next   = candidate[VW-1:0] - 1'b1;
                    s_next   = '0;
                    idx_next = '0;
                    if (candidate[VW-1:0] < VW'(2))
                    begin
                        res_next   = 1'b0;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_STRIP;
                end
            end
            S_STRIP:
            begin
                if (d_reg[0])
                    state_next = S_BASE;
                else
                begin
                    d_next = d_reg >> 1;
                    s_next = s_reg + 1'b1;
                end
            end
            S_BASE:
            begin
                if (n_reg == base)
                begin
                    res_next   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    x_next     = VW'(1);
                    bit_next   = CW'(VW-1);
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                req.start  = 1'b1;
                state_next = S_SQW;
            end
            S_SQW:
            begin
                if (mul_done)
                begin
                    x_next     = mul_res;
                    state_next = S_ML;
                end
            end
            S_ML:
            begin
                // scan the unreduced base, accumulate the reduced residue
                if (d_reg[bit_reg])
                begin
                    req = '{start: 1'b1, a: base, b: x_reg};
                    state_next = S_MLW;
                end
                else
                    state_next = S_NB;
            end
            S_MLW:
            begin
                if (mul_done)
                begin
                    x_next     = mul_res;
                    state_next = S_NB;
                end
            end
            S_NB:
            begin
                if (bit_reg == '0)
                    state_next = S_CHK;
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = S_SQ;
                end
            end
            S_CHK:
            begin
                r_next = CW'(1);
                if (x_reg == VW'(1) || x_reg == nm1)
                begin
                    if (idx_reg == 2'd2)
                    begin
                        res_next   = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_BASE;
                    end
                end
                else
                    state_next = S_LOOP;
            end
            S_LOOP:
            begin
                if (r_reg < s_reg)
                begin
                    req.start  = 1'b1;
                    state_next = S_LW;
                end
                else
                begin
                    res_next   = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_LW:
            begin
                if (mul_done)
                begin
                    x_next = mul_res;
                    r_next = r_reg + 1'b1;
                    if (mul_res == nm1)
                    begin
                        if (idx_reg == 2'd2)
                        begin
                            res_next   = 1'b1;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_BASE;
                        end
                    end
                    else
                        state_next = S_LOOP;
                end
            end
            S_OUT:
            begin
                // hold until the output slot is free
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    pf_next    = res_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        x_reg   <= x_next;
        s_reg   <= s_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
        pf_reg  <= pf_next;
    end

    assign out_valid  = ov_reg;
    assign prime_flag = pf_reg;
endmodule
`default_nettype wire
